@@ rtl/core/trail_history_update_core_assert.svh @@
// ----------------------------------------------------------------------------
// trail history update core assertion macros
// Concurrent checks on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef TRAIL_HISTORY_UPDATE_CORE_ASSERT_SVH
`define TRAIL_HISTORY_UPDATE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define THU_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("trail history check failed");
`define THU_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("trail history check failed");
`else
`define THU_ASSERT_IMP(lbl, ante, cons)
`define THU_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ rtl/core/thu_pkg.sv @@
// ----------------------------------------------------------------------------
// thu_pkg
// Shared types, constants and helpers of the trail history update core.
// ----------------------------------------------------------------------------
package thu_pkg;

   localparam int MAX_SEGMENTS = 32;
   localparam int NPTS         = MAX_SEGMENTS + 1;
   localparam int IDX_W        = $clog2(NPTS + 1);

   localparam logic [15:0] FADE_ONE = 16'd32768;

   // register indexes
   localparam logic [2:0] CSR_SAMPLE_INTERVAL = 3'd0;
   localparam logic [2:0] CSR_MAX_SEGMENTS    = 3'd1;
   localparam logic [2:0] CSR_FADE_RATE       = 3'd2;
   localparam logic [2:0] CSR_FORCE_X         = 3'd3;
   localparam logic [2:0] CSR_FORCE_Y         = 3'd4;
   localparam logic [2:0] CSR_FORCE_Z         = 3'd5;

   // arithmetic unit operations
   localparam logic [1:0] OP_MUL  = 2'd0;
   localparam logic [1:0] OP_DIV  = 2'd1;
   localparam logic [1:0] OP_SQRT = 2'd2;

   localparam int MUL_STEPS  = 33;
   localparam int DIV_STEPS  = 64;
   localparam int SQRT_STEPS = 32;

   typedef struct packed {
      logic [15:0] fade;
      logic [31:0] z;
      logic [31:0] y;
      logic [31:0] x;
   } point_type;

   typedef struct packed {
      logic       start;
      logic [1:0] op;
   } arith_req_type;

   typedef struct packed {
      logic busy;
      logic done;
   } arith_rsp_type;

   // a - b on two signed 32 bit values
   function automatic logic [32:0] sub33(input logic [31:0] a, input logic [31:0] b);
      sub33 = {a[31], a} - {b[31], b};
   endfunction

   function automatic logic [31:0] mag33(input logic [32:0] v);
      logic [32:0] n;
      begin
         n = -v;
         mag33 = v[32] ? n[31:0] : v[31:0];
      end
   endfunction

   // saturate a signed 36 bit value to 32 bits
   function automatic logic [31:0] sat32(input logic [35:0] v);
      if (!v[35] && (v[35:31] != 5'h00)) begin
         sat32 = 32'h7FFF_FFFF;
      end else if (v[35] && (v[35:31] != 5'h1F)) begin
         sat32 = 32'h8000_0000;
      end else begin
         sat32 = v[31:0];
      end
   endfunction

   function automatic logic [15:0] decay(input logic [15:0] f, input logic [23:0] fd);
      decay = ({8'd0, f} > fd) ? (f - fd[15:0]) : 16'd0;
   endfunction

endpackage

@@ rtl/core/trail_history_update_core.sv @@
// ----------------------------------------------------------------------------
// trail_history_update_core
// Motion trail history: keeps up to max_segments+1 points, with max_segments taken as
// 1 to 32, and emits the trail after every word.
// ----------------------------------------------------------------------------
// One word is taken at a time and the trail is streamed out once it is done;
// req_tready is high only while the block is idle. A clear or a word without a
// valid root goes straight to emission. A tick on a non-empty trail runs five
// bit-serial multiplies for the fade step and the distance test, and, when a
// force is set, a force shift of every point and a pull of each link; each link
// runs three squares, a 64 bit square root, three multiplies and three 64 bit
// divides through the one shared serial unit, and every point goes through the
// trail memory, which has one write port, one read port and registered read
// data. Emission waits on rsp_tready.
// ----------------------------------------------------------------------------
`include "trail_history_update_core_assert.svh"

module trail_history_update_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [111:0] req_tdata,   // step_time, root_x, root_y, root_z
   input  logic [1:0]   req_tuser,   // action, root_valid
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata,   // point_index, point_x, point_y, point_z, point_fade
   output logic [1:0]   rsp_tuser,   // point_valid, trail_full
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [31:0]  csr_wdata
);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_SD0   = 5'd1;
   localparam logic [4:0] S_SD1   = 5'd2;
   localparam logic [4:0] S_FD    = 5'd3;
   localparam logic [4:0] S_HRD   = 5'd4;
   localparam logic [4:0] S_HLAT  = 5'd5;
   localparam logic [4:0] S_HSQ   = 5'd6;
   localparam logic [4:0] S_SISQ  = 5'd7;
   localparam logic [4:0] S_SHRD  = 5'd8;
   localparam logic [4:0] S_SHWR  = 5'd9;
   localparam logic [4:0] S_HWR   = 5'd10;
   localparam logic [4:0] S_DRD   = 5'd11;
   localparam logic [4:0] S_DWR   = 5'd12;
   localparam logic [4:0] S_FCHK  = 5'd13;
   localparam logic [4:0] S_FSTEP = 5'd14;
   localparam logic [4:0] S_FRD   = 5'd15;
   localparam logic [4:0] S_FWR   = 5'd16;
   localparam logic [4:0] S_LPREP = 5'd17;
   localparam logic [4:0] S_LPREV = 5'd18;
   localparam logic [4:0] S_LCHK  = 5'd19;
   localparam logic [4:0] S_LCUR  = 5'd20;
   localparam logic [4:0] S_LSQ   = 5'd21;
   localparam logic [4:0] S_LSQRT = 5'd22;
   localparam logic [4:0] S_LMUL  = 5'd23;
   localparam logic [4:0] S_LDIV  = 5'd24;
   localparam logic [4:0] S_LWR   = 5'd25;
   localparam logic [4:0] S_CPWR  = 5'd26;
   localparam logic [4:0] S_ERD   = 5'd27;
   localparam logic [4:0] S_ELAT  = 5'd28;
   localparam logic [4:0] S_EOUT  = 5'd29;

   localparam int IW = thu_pkg::IDX_W;

   // configuration
   logic [30:0]      si_ff;
   logic [5:0]       maxseg_ff;
   logic [23:0]      frate_ff;
   logic [2:0][31:0] force_ff;

   // sequencer state
   logic [4:0]        state_ff, state_in;
   logic [IW-1:0]     count_ff, count_in;
   logic              full_ff, full_in;
   logic [IW-1:0]     k_ff, k_in;
   logic [IW-1:0]     nh_ff, nh_in;
   logic [1:0]        ax_ff, ax_in;
   logic              issued_ff, issued_in;
   logic [15:0]       dt_ff, dt_in;
   logic [2:0][31:0]  root_ff, root_in;
   logic [23:0]       fd_ff, fd_in;
   logic [2:0][31:0]  head_ff, head_in;
   logic [65:0]       sum_ff, sum_in;
   logic [2:0][32:0]  step_ff, step_in;
   logic [2:0][31:0]  prev_ff, prev_in;
   logic [2:0][31:0]  curp_ff, curp_in;
   logic [15:0]       curf_ff, curf_in;
   logic [2:0][31:0]  m_ff, m_in;
   logic [2:0]        neg_ff, neg_in;
   logic [32:0]       len_ff, len_in;

   // result register
   logic               ov_ff, ov_in;
   logic [IW-1:0]      oidx_ff, oidx_in;
   thu_pkg::point_type opt_ff, opt_in;
   logic               opv_ff, opv_in;
   logic               ofull_ff, ofull_in;
   logic               olast_ff, olast_in;

   // memory and arithmetic unit hookup
   logic               mem_we;
   logic [IW-1:0]      mem_waddr;
   thu_pkg::point_type mem_wdata;
   logic [IW-1:0]      mem_raddr;
   thu_pkg::point_type mem_rdata;
   logic [2:0][31:0]   rpos;

   thu_pkg::arith_req_type arith_req;
   thu_pkg::arith_rsp_type arith_rsp;
   logic [63:0]            arith_opa;
   logic [63:0]            arith_opb;
   logic [63:0]            arith_res;
   logic                   arith_go;

   // scratch
   logic [IW-1:0]    segs;
   logic [40:0]      fdsum;
   logic [47:0]      rnd;
   logic [32:0]      rmag;
   logic [2:0][32:0] dtmp;
   logic [2:0][31:0] mtmp;
   logic [35:0]      base;
   logic [35:0]      moved;

   thu_trail_mem u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   thu_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .req    (arith_req),
      .opa    (arith_opa),
      .opb    (arith_opb),
      .rsp    (arith_rsp),
      .result (arith_res)
   );

   assign rpos = {mem_rdata.z, mem_rdata.y, mem_rdata.x};

   always_comb begin
      if (maxseg_ff == 6'd0) begin
         segs = IW'(1);
      end else if (maxseg_ff > 6'(thu_pkg::MAX_SEGMENTS)) begin
         segs = IW'(thu_pkg::MAX_SEGMENTS);
      end else begin
         segs = IW'(maxseg_ff);
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         si_ff     <= 31'd65536;
         maxseg_ff <= 6'd16;
         frate_ff  <= 24'd65536;
         force_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            thu_pkg::CSR_SAMPLE_INTERVAL: si_ff       <= csr_wdata[30:0];
            thu_pkg::CSR_MAX_SEGMENTS:    maxseg_ff   <= csr_wdata[5:0];
            thu_pkg::CSR_FADE_RATE:       frate_ff    <= csr_wdata[23:0];
            thu_pkg::CSR_FORCE_X:         force_ff[0] <= csr_wdata;
            thu_pkg::CSR_FORCE_Y:         force_ff[1] <= csr_wdata;
            thu_pkg::CSR_FORCE_Z:         force_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      full_in   = full_ff;
      k_in      = k_ff;
      nh_in     = nh_ff;
      ax_in     = ax_ff;
      issued_in = issued_ff;
      dt_in     = dt_ff;
      root_in   = root_ff;
      fd_in     = fd_ff;
      head_in   = head_ff;
      sum_in    = sum_ff;
      step_in   = step_ff;
      prev_in   = prev_ff;
      curp_in   = curp_ff;
      curf_in   = curf_ff;
      m_in      = m_ff;
      neg_in    = neg_ff;
      len_in    = len_ff;
      ov_in     = ov_ff;
      oidx_in   = oidx_ff;
      opt_in    = opt_ff;
      opv_in    = opv_ff;
      ofull_in  = ofull_ff;
      olast_in  = olast_ff;

      mem_we    = 1'b0;
      mem_waddr = k_ff;
      mem_wdata = mem_rdata;
      mem_raddr = k_ff;

      arith_req.start = 1'b0;
      arith_req.op    = thu_pkg::OP_MUL;
      arith_opa       = '0;
      arith_opb       = '0;
      arith_go        = issued_ff && arith_rsp.done;

      fdsum = arith_res[40:0] + 41'd65536;
      rnd   = arith_res[47:0] + 48'd32768;
      rmag  = {1'b0, rnd[47:16]};
      base  = {{4{prev_ff[ax_ff][31]}}, prev_ff[ax_ff]};
      moved = neg_ff[ax_ff] ? (base - {2'b00, arith_res[33:0]})
                            : (base + {2'b00, arith_res[33:0]});
      for (int c = 0; c < 3; c++) begin
         dtmp[c] = thu_pkg::sub33(rpos[c], prev_ff[c]);
         mtmp[c] = thu_pkg::mag33(dtmp[c]);
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               dt_in   = req_tdata[15:0];
               root_in = req_tdata[111:16];
               k_in    = '0;
               if (req_tuser[0]) begin
                  count_in = '0;
                  full_in  = 1'b0;
                  state_in = S_ERD;
               end else if (!req_tuser[1]) begin
                  state_in = S_ERD;
               end else if (count_ff == '0) begin
                  state_in = S_SD0;
               end else begin
                  state_in = S_FD;
               end
            end
         end
         S_SD0: begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = {thu_pkg::FADE_ONE, root_ff};
            state_in  = S_SD1;
         end
         S_SD1: begin
            mem_we    = 1'b1;
            mem_waddr = IW'(1);
            mem_wdata = {thu_pkg::FADE_ONE, root_ff};
            count_in  = IW'(2);
            full_in   = 1'b0;
            state_in  = S_FCHK;
         end
         S_FD: begin
            arith_req.start = !issued_ff;
            issued_in       = !arith_go;
            arith_opa       = {40'd0, frate_ff};
            arith_opb       = {48'd0, dt_ff};
            if (arith_go) begin
               fd_in    = fdsum[40:17];
               state_in = S_HRD;
            end
         end
         S_HRD: begin
            mem_raddr = '0;
            state_in  = S_HLAT;
         end
         S_HLAT: begin
            head_in  = rpos;
            ax_in    = '0;
            sum_in   = '0;
            state_in = S_HSQ;
         end
         S_HSQ: begin
            arith_req.start = !issued_ff;
            issued_in       = !arith_go;
            arith_opa = {32'd0, thu_pkg::mag33(thu_pkg::sub33(root_ff[ax_ff], head_ff[ax_ff]))};
            arith_opb = arith_opa;
            if (arith_go) begin
               sum_in = sum_ff + {2'b00, arith_res};
               if (ax_ff == 2'd2) begin
                  state_in = S_SISQ;
               end else begin
                  ax_in = ax_ff + 2'd1;
               end
            end
         end
         S_SISQ: begin
            arith_req.start = !issued_ff;
            issued_in       = !arith_go;
            arith_opa       = {33'd0, si_ff};
            arith_opb       = {33'd0, si_ff};
            if (arith_go) begin
               if (sum_ff >= {2'b00, arith_res}) begin
                  // far enough: shift the trail back by one point
                  if (count_ff <= segs) begin
                     count_in = count_ff + IW'(1);
                     k_in     = count_ff;
                  end else begin
                     full_in = 1'b1;
                     k_in    = count_ff - IW'(1);
                  end
                  state_in = S_SHRD;
               end else begin
                  k_in     = '0;
                  state_in = S_DRD;
               end
            end
         end
         S_SHRD: begin
            mem_raddr = k_ff - IW'(1);
            state_in  = S_SHWR;
         end
         S_SHWR: begin
            mem_we    = 1'b1;
            mem_wdata = {thu_pkg::decay(mem_rdata.fade, fd_ff), rpos};
            if (k_ff == IW'(1)) begin
               state_in = S_HWR;
            end else begin
               k_in     = k_ff - IW'(1);
               state_in = S_SHRD;
            end
         end
         S_HWR: begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = {thu_pkg::FADE_ONE, root_ff};
            state_in  = S_FCHK;
         end
         S_DRD: begin
            state_in = S_DWR;
         end
         S_DWR: begin
            mem_we    = 1'b1;
            mem_wdata = {thu_pkg::decay(mem_rdata.fade, fd_ff), rpos};
            if (k_ff == count_ff - IW'(1)) begin
               state_in = S_FCHK;
            end else begin
               k_in     = k_ff + IW'(1);
               state_in = S_DRD;
            end
         end
         S_FCHK: begin
            k_in  = '0;
            ax_in = '0;
            if (force_ff == '0) begin
               state_in = S_ERD;
            end else begin
               state_in = S_FSTEP;
            end
         end
         S_FSTEP: begin
            arith_req.start = !issued_ff;
            issued_in       = !arith_go;
            arith_opa = {32'd0, thu_pkg::mag33({force_ff[ax_ff][31], force_ff[ax_ff]})};
            arith_opb = {48'd0, dt_ff};
            if (arith_go) begin
               step_in[ax_ff] = force_ff[ax_ff][31] ? -rmag : rmag;
               if (ax_ff == 2'd2) begin
                  state_in = S_FRD;
               end else begin
                  ax_in = ax_ff + 2'd1;
               end
            end
         end
         S_FRD: begin
            state_in = S_FWR;
         end
         S_FWR: begin
            mem_we = 1'b1;
            for (int c = 0; c < 3; c++) begin
               mem_wdata[32*c +: 32] = thu_pkg::sat32({{4{rpos[c][31]}}, rpos[c]}
                                                     + {{3{step_ff[c][32]}}, step_ff[c]});
            end
            if (k_ff == count_ff - IW'(1)) begin
               state_in = S_LPREP;
            end else begin
               k_in     = k_ff + IW'(1);
               state_in = S_FRD;
            end
         end
         S_LPREP: begin
            mem_raddr = '0;
            nh_in     = full_ff ? count_ff : (count_ff - IW'(1));
            k_in      = IW'(1);
            state_in  = S_LPREV;
         end
         S_LPREV: begin
            prev_in  = rpos;
            state_in = S_LCHK;
         end
         S_LCHK: begin
            if (k_ff < nh_ff) begin
               state_in = S_LCUR;
            end else if (!full_ff) begin
               state_in = S_CPWR;
            end else begin
               k_in     = '0;
               state_in = S_ERD;
            end
         end
         S_LCUR: begin
            curp_in = rpos;
            curf_in = mem_rdata.fade;
            for (int c = 0; c < 3; c++) begin
               neg_in[c] = dtmp[c][32];
               // halve all axes when one is at or beyond 2^31
               m_in[c] = (mtmp[0][31] || mtmp[1][31] || mtmp[2][31]) ? (mtmp[c] >> 1)
                                                                      : mtmp[c];
            end
            ax_in    = '0;
            sum_in   = '0;
            state_in = S_LSQ;
         end
         S_LSQ: begin
            arith_req.start = !issued_ff;
            issued_in       = !arith_go;
            arith_opa       = {32'd0, m_ff[ax_ff]};
            arith_opb       = {32'd0, m_ff[ax_ff]};
            if (arith_go) begin
               sum_in = sum_ff + {2'b00, arith_res};
               if (ax_ff == 2'd2) begin
                  state_in = S_LSQRT;
               end else begin
                  ax_in = ax_ff + 2'd1;
               end
            end
         end
         S_LSQRT: begin
            arith_req.start = !issued_ff;
            arith_req.op    = thu_pkg::OP_SQRT;
            issued_in       = !arith_go;
            arith_opa       = sum_ff[63:0];
            if (arith_go) begin
               len_in = arith_res[32:0];
               ax_in  = '0;
               if (arith_res == 64'd0) begin
                  // zero length link stays as it is
                  prev_in  = curp_ff;
                  k_in     = k_ff + IW'(1);
                  state_in = S_LCHK;
               end else begin
                  state_in = S_LMUL;
               end
            end
         end
         S_LMUL: begin
            arith_req.start = !issued_ff;
            issued_in       = !arith_go;
            arith_opa       = {32'd0, m_ff[ax_ff]};
            arith_opb       = {33'd0, si_ff};
            if (arith_go) begin
               sum_in   = {2'b00, arith_res + {32'd0, len_ff[32:1]}};
               state_in = S_LDIV;
            end
         end
         S_LDIV: begin
            arith_req.start = !issued_ff;
            arith_req.op    = thu_pkg::OP_DIV;
            issued_in       = !arith_go;
            arith_opa       = sum_ff[63:0];
            arith_opb       = {31'd0, len_ff};
            if (arith_go) begin
               curp_in[ax_ff] = thu_pkg::sat32(moved);
               if (ax_ff == 2'd2) begin
                  state_in = S_LWR;
               end else begin
                  ax_in    = ax_ff + 2'd1;
                  state_in = S_LMUL;
               end
            end
         end
         S_LWR: begin
            mem_we    = 1'b1;
            mem_wdata = {curf_ff, curp_ff};
            prev_in   = curp_ff;
            k_in      = k_ff + IW'(1);
            state_in  = S_LCHK;
         end
         S_CPWR: begin
            // tail follows its predecessor while the trail is still growing
            mem_we    = 1'b1;
            mem_wdata = {mem_rdata.fade, prev_ff};
            k_in      = '0;
            state_in  = S_ERD;
         end
         S_ERD: begin
            if (count_ff == '0) begin
               ov_in    = 1'b1;
               oidx_in  = '0;
               opt_in   = '0;
               opv_in   = 1'b0;
               ofull_in = 1'b0;
               olast_in = 1'b1;
               state_in = S_EOUT;
            end else begin
               state_in = S_ELAT;
            end
         end
         S_ELAT: begin
            ov_in    = 1'b1;
            oidx_in  = k_ff;
            opt_in   = mem_rdata;
            opv_in   = 1'b1;
            ofull_in = full_ff;
            olast_in = (k_ff == count_ff - IW'(1));
            state_in = S_EOUT;
         end
         S_EOUT: begin
            if (rsp_tready) begin
               ov_in = 1'b0;
               if (olast_ff) begin
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + IW'(1);
                  state_in = S_ERD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         full_ff   <= 1'b0;
         issued_ff <= 1'b0;
         ov_ff     <= 1'b0;
         k_ff      <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         full_ff   <= full_in;
         issued_ff <= issued_in;
         ov_ff     <= ov_in;
         k_ff      <= k_in;
      end
      nh_ff    <= nh_in;
      ax_ff    <= ax_in;
      dt_ff    <= dt_in;
      root_ff  <= root_in;
      fd_ff    <= fd_in;
      head_ff  <= head_in;
      sum_ff   <= sum_in;
      step_ff  <= step_in;
      prev_ff  <= prev_in;
      curp_ff  <= curp_in;
      curf_ff  <= curf_in;
      m_ff     <= m_in;
      neg_ff   <= neg_in;
      len_ff   <= len_in;
      oidx_ff  <= oidx_in;
      opt_ff   <= opt_in;
      opv_ff   <= opv_in;
      ofull_ff <= ofull_in;
      olast_ff <= olast_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {2'b00, opt_ff, oidx_ff};
   assign rsp_tuser  = {ofull_ff, opv_ff};
   assign rsp_tlast  = olast_ff;

   `THU_ASSERT_IMP(a_ready_no_pending, req_tready, !rsp_tvalid)
   `THU_ASSERT_IMP(a_empty_is_last, rsp_tvalid && !rsp_tuser[0], rsp_tlast)
   `THU_ASSERT_IMP(a_arith_free, arith_req.start, !arith_rsp.busy)
   `THU_ASSERT_IMP(a_count_range, count_ff != '0, (count_ff >= IW'(2)) && (count_ff <= IW'(thu_pkg::NPTS)))
   `THU_ASSERT_NXT(a_emit_next, (state_ff == S_EOUT) && rsp_tready && !olast_ff, state_ff == S_ERD)

endmodule

@@ rtl/core/thu_trail_mem.sv @@
// ----------------------------------------------------------------------------
// thu_trail_mem
// Trail point store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module thu_trail_mem (
   input  logic                          clock,
   input  logic                          we,
   input  logic [thu_pkg::IDX_W-1:0]     waddr,
   input  thu_pkg::point_type            wdata,
   input  logic [thu_pkg::IDX_W-1:0]     raddr,
   output thu_pkg::point_type            rdata
);

   thu_pkg::point_type mem [thu_pkg::NPTS];
   thu_pkg::point_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we && (waddr < thu_pkg::IDX_W'(thu_pkg::NPTS))) begin
         mem[waddr] <= wdata;
      end
      if (raddr < thu_pkg::IDX_W'(thu_pkg::NPTS)) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/thu_arith.sv @@
// ----------------------------------------------------------------------------
// thu_arith
// Shared bit-serial unit: unsigned multiply, 64 by 64 divide, 64 bit square root.
// ----------------------------------------------------------------------------
module thu_arith (
   input  logic                   clock,
   input  logic                   reset,
   input  thu_pkg::arith_req_type req,
   input  logic [63:0]            opa,
   input  logic [63:0]            opb,
   output thu_pkg::arith_rsp_type rsp,
   output logic [63:0]            result
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [1:0]  op_ff, op_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [64:0] acc_ff, acc_in;
   logic [63:0] aux_ff, aux_in;
   logic [63:0] bb_ff, bb_in;
   logic [64:0] trial;
   logic [64:0] rb;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      aux_in  = aux_ff;
      bb_in   = bb_ff;
      trial   = {acc_ff[63:0], aux_ff[63]};
      rb      = {1'b0, aux_ff} + {1'b0, bb_ff};
      if (!busy_ff) begin
         if (req.start) begin
            busy_in = 1'b1;
            op_in   = req.op;
            unique case (req.op)
               thu_pkg::OP_DIV: begin
                  acc_in = '0;
                  aux_in = opa;
                  bb_in  = opb;
                  cnt_in = 7'(thu_pkg::DIV_STEPS - 1);
               end
               thu_pkg::OP_SQRT: begin
                  acc_in = {1'b0, opa};
                  aux_in = '0;
                  bb_in  = 64'h4000_0000_0000_0000;
                  cnt_in = 7'(thu_pkg::SQRT_STEPS - 1);
               end
               default: begin
                  acc_in = '0;
                  aux_in = opa;
                  bb_in  = opb;
                  cnt_in = 7'(thu_pkg::MUL_STEPS - 1);
               end
            endcase
         end
      end else begin
         unique case (op_ff)
            thu_pkg::OP_DIV: begin
               // restoring division, one quotient bit per cycle
               if (trial >= {1'b0, bb_ff}) begin
                  acc_in = trial - {1'b0, bb_ff};
                  aux_in = {aux_ff[62:0], 1'b1};
               end else begin
                  acc_in = trial;
                  aux_in = {aux_ff[62:0], 1'b0};
               end
            end
            thu_pkg::OP_SQRT: begin
               if (acc_ff >= rb) begin
                  acc_in = acc_ff - rb;
                  aux_in = (aux_ff >> 1) + bb_ff;
               end else begin
                  aux_in = aux_ff >> 1;
               end
               bb_in = bb_ff >> 2;
            end
            default: begin
               if (bb_ff[0]) begin
                  acc_in = acc_ff + {1'b0, aux_ff};
               end
               aux_in = aux_ff << 1;
               bb_in  = bb_ff >> 1;
            end
         endcase
         if (cnt_ff == 7'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 7'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      aux_ff <= aux_in;
      bb_ff  <= bb_in;
   end

   assign rsp.busy = busy_ff;
   assign rsp.done = done_ff;
   assign result   = (op_ff == thu_pkg::OP_MUL) ? acc_ff[63:0] : aux_ff;

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: trail history update core testbench
// Streams tick, clear and idle-root words into the core under several register
// settings, predicts every emitted trail point and compares each response word
// field by field, with random gaps and stalls on both streams.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      bit [5:0]  index;
      bit [31:0] x;
      bit [31:0] y;
      bit [31:0] z;
      bit [15:0] fade;
      bit        pvalid;
      bit        full;
      bit        last;
   } point_due_type;

   class trail_scoreboard;
      int unsigned   interval;
      int unsigned   segs_reg;
      int unsigned   rate;
      int            force_v[3];
      int            pos[3][thu_pkg::NPTS];
      bit [15:0]     fades[thu_pkg::NPTS];
      int unsigned   count;
      bit            full;
      point_due_type pending[$];
      int            errors;

      function new();
         interval = 65536;
         segs_reg = 16;
         rate     = 65536;
         force_v  = '{0, 0, 0};
         count    = 0;
         full     = 0;
         errors   = 0;
      endfunction

      function void set_reg(bit [2:0] addr, bit [31:0] v);
         case (addr)
            thu_pkg::CSR_SAMPLE_INTERVAL: interval = v[30:0];
            thu_pkg::CSR_MAX_SEGMENTS:    segs_reg = v[5:0];
            thu_pkg::CSR_FADE_RATE:       rate = v[23:0];
            thu_pkg::CSR_FORCE_X:         force_v[0] = v;
            thu_pkg::CSR_FORCE_Y:         force_v[1] = v;
            thu_pkg::CSR_FORCE_Z:         force_v[2] = v;
            default: ;
         endcase
      endfunction

      function int sat(longint v);
         if (v > 64'sh7FFF_FFFF) return 32'h7FFF_FFFF;
         if (v < -64'sh8000_0000) return 32'h8000_0000;
         return int'(v);
      endfunction

      function longint unsigned mag(longint v);
         return (v < 0) ? longint'(-v) : v;
      endfunction

      function longint unsigned root_of(longint unsigned x);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > x) b = b >> 2;
         while (b != 0) begin
            if (x >= r + b) begin
               x = x - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function bit root_moved(int root[3]);
         longint unsigned sum, m, sq;
         sum = 0;
         for (int c = 0; c < 3; c++) begin
            m  = mag(longint'(root[c]) - longint'(pos[c][0]));
            sq = m * m;
            if (sum > 64'hFFFF_FFFF_FFFF_FFFF - sq) return 1;
            sum += sq;
         end
         return sum >= longint'(interval) * longint'(interval);
      endfunction

      function void pull_link(int i);
         longint          d[3];
         longint unsigned m[3], mx, sum, len, off;
         longint          base;
         mx  = 0;
         sum = 0;
         for (int c = 0; c < 3; c++) begin
            d[c] = longint'(pos[c][i]) - longint'(pos[c][i-1]);
            m[c] = mag(d[c]);
            if (m[c] > mx) mx = m[c];
         end
         // halve when a component does not fit 31 bits
         if (mx >= (64'd1 << 31))
            for (int c = 0; c < 3; c++) m[c] = m[c] >> 1;
         for (int c = 0; c < 3; c++) sum += m[c] * m[c];
         len = root_of(sum);
         if (len == 0) return;
         for (int c = 0; c < 3; c++) begin
            off  = (m[c] * longint'(interval) + len / 2) / len;
            base = pos[c][i-1];
            pos[c][i] = sat(d[c] < 0 ? base - longint'(off) : base + longint'(off));
         end
      endfunction

      function bit [15:0] fade_down(bit [15:0] f, longint unsigned fd);
         return (longint'(f) > fd) ? f - fd[15:0] : 16'd0;
      endfunction

      function void advance(int unsigned dt, int root[3]);
         int unsigned    segs, nh;
         longint unsigned fd, r;
         longint         p, stepv[3];
         segs = segs_reg;
         if (segs < 1) segs = 1;
         if (segs > thu_pkg::MAX_SEGMENTS) segs = thu_pkg::MAX_SEGMENTS;
         if (count == 0) begin
            // empty trail seeds two root points
            full  = 0;
            count = 2;
            for (int k = 0; k < 2; k++) begin
               for (int c = 0; c < 3; c++) pos[c][k] = root[c];
               fades[k] = thu_pkg::FADE_ONE;
            end
         end else begin
            fd = (longint'(rate) * dt + 65536) >> 17;
            if (root_moved(root)) begin
               if (count <= segs) count++;
               else full = 1;
               for (int k = count - 1; k > 0; k--) begin
                  for (int c = 0; c < 3; c++) pos[c][k] = pos[c][k-1];
                  fades[k] = fade_down(fades[k-1], fd);
               end
               for (int c = 0; c < 3; c++) pos[c][0] = root[c];
               fades[0] = thu_pkg::FADE_ONE;
            end else begin
               for (int k = 0; k < count; k++) fades[k] = fade_down(fades[k], fd);
            end
         end
         if (force_v[0] != 0 || force_v[1] != 0 || force_v[2] != 0) begin
            nh = count;
            for (int c = 0; c < 3; c++) begin
               p = longint'(dt) * longint'(force_v[c]);
               r = (mag(p) + 32768) >> 16;
               stepv[c] = (p < 0) ? -longint'(r) : longint'(r);
            end
            for (int k = 0; k < count; k++)
               for (int c = 0; c < 3; c++) pos[c][k] = sat(longint'(pos[c][k]) + stepv[c]);
            if (!full) nh--;
            for (int k = 1; k < nh; k++) pull_link(k);
            // a growing trail keeps its tail on the point ahead of it
            if (!full && nh >= 1 && nh < thu_pkg::NPTS)
               for (int c = 0; c < 3; c++) pos[c][nh] = pos[c][nh-1];
         end
      endfunction

      function void note(bit clear, bit [15:0] dt, bit rvalid, int root[3]);
         point_due_type e;
         if (clear) begin
            count = 0;
            full  = 0;
         end else if (rvalid) begin
            advance(dt, root);
         end
         if (count == 0) begin
            e = '{default: 0};
            e.last = 1;
            pending = {pending, e};
         end else begin
            for (int k = 0; k < count; k++) begin
               e.index  = k;
               e.x      = pos[0][k];
               e.y      = pos[1][k];
               e.z      = pos[2][k];
               e.fade   = fades[k];
               e.pvalid = 1;
               e.full   = full;
               e.last   = (k + 1 == count);
               pending = {pending, e};
            end
         end
      endfunction

      task report(string what, longint unsigned got, longint unsigned want);
         $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
         errors++;
      endtask

      task check(point_due_type g);
         point_due_type e;
         if (pending.size() == 0) begin
            report("unexpected word", g.index, 0);
         end else begin
            e = pending.pop_front();
            if (g.index  != e.index)  report("point_index", g.index, e.index);
            if (g.x      != e.x)      report("point_x", g.x, e.x);
            if (g.y      != e.y)      report("point_y", g.y, e.y);
            if (g.z      != e.z)      report("point_z", g.z, e.z);
            if (g.fade   != e.fade)   report("point_fade", g.fade, e.fade);
            if (g.pvalid != e.pvalid) report("point_valid", g.pvalid, e.pvalid);
            if (g.full   != e.full)   report("trail_full", g.full, e.full);
            if (g.last   != e.last)   report("last", g.last, e.last);
         end
      endtask
   endclass

   localparam int CYCLE_LIMIT = 25000000;

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [111:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [119:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_we = 0;
   logic [2:0]   csr_addr = '0;
   logic [31:0]  csr_wdata = '0;

   trail_scoreboard trail_sb = new();
   int   cycles = 0;
   int   stall = 0;
   bit   no_idle = 0;
   int   last_root[3] = '{0, 0, 0};
   int   words_sent = 0;
   int   words_seen = 0;

   trail_history_update_core i_dut (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // response side: check accepted words, then draw the next stall
   always @(posedge clock) begin
      point_due_type g;
      if (!reset && rsp_tvalid && rsp_tready) begin
         g.index  = rsp_tdata[5:0];
         g.x      = rsp_tdata[37:6];
         g.y      = rsp_tdata[69:38];
         g.z      = rsp_tdata[101:70];
         g.fade   = rsp_tdata[117:102];
         g.pvalid = rsp_tuser[0];
         g.full   = rsp_tuser[1];
         g.last   = rsp_tlast;
         trail_sb.check(g);
         words_seen++;
      end
      if (reset) begin
         rsp_tready <= 0;
      end else if (stall > 0) begin
         stall--;
         rsp_tready <= 0;
      end else if (!no_idle && $urandom_range(0, 99) < 8) begin
         stall = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(15, 60);
         rsp_tready <= 0;
      end else begin
         rsp_tready <= 1;
      end
   end

   task send_word(bit clear, bit [15:0] dt, bit rvalid, int rx, int ry, int rz);
      int root[3];
      int gap;
      root = '{rx, ry, rz};
      req_tvalid <= 1;
      req_tdata  <= {rz, ry, rx, dt};
      req_tuser  <= {rvalid, clear};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      trail_sb.note(clear, dt, rvalid, root);
      words_sent++;
      if (rvalid && !clear) last_root = root;
      gap = 0;
      if (!no_idle) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: gap = $urandom_range(1, 3);
            5:             gap = $urandom_range(10, 50);
            default:       gap = 0;
         endcase
      end
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task wait_drained();
      // drop the last word so it is not taken a second time
      if (req_tvalid) req_tvalid <= 0;
      while (trail_sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task configure(bit [31:0] si, bit [31:0] segs, bit [31:0] rate,
                  bit [31:0] fx, bit [31:0] fy, bit [31:0] fz);
      bit [31:0] vals[6];
      vals = '{si, segs, rate, fx, fy, fz};
      wait_drained();
      for (int a = 0; a < 6; a++) begin
         csr_we    <= 1;
         csr_addr  <= a;
         csr_wdata <= vals[a];
         trail_sb.set_reg(a, vals[a]);
         @(posedge clock);
      end
      csr_we <= 0;
      @(posedge clock);
   endtask

   function int near_coord(int base, int unsigned si);
      longint span;
      span = (si == 0) ? 4 : ((si > 32'h4000_0000) ? 32'h4000_0000 : si);
      return trail_sb.sat(longint'(base) + longint'($urandom_range(0, 2 * span)) - span);
   endfunction

   task random_words(int n);
      int unsigned kind;
      int          rx, ry, rz;
      bit [15:0]   dt;
      for (int i = 0; i < n; i++) begin
         kind = $urandom_range(0, 99);
         dt   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom;
         if (kind < 80) begin
            rx = near_coord(last_root[0], trail_sb.interval);
            ry = near_coord(last_root[1], trail_sb.interval);
            rz = near_coord(last_root[2], trail_sb.interval);
            send_word(0, dt, 1, rx, ry, rz);
         end else if (kind < 88) begin
            send_word(0, dt, 1, $urandom, $urandom, $urandom);
         end else if (kind < 94) begin
            send_word(0, dt, 0, $urandom, $urandom, $urandom);
         end else begin
            send_word(1, dt, $urandom_range(0, 1), $urandom, $urandom, $urandom);
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: seeding, idle root, no move, extremes, clear
      send_word(0, 16'd100, 0, 0, 0, 0);
      send_word(0, 16'd1000, 1, 32'sh0001_0000, 0, 0);
      send_word(0, 16'd0, 1, 32'sh0001_0000, 0, 0);
      send_word(0, 16'hFFFF, 1, 32'sh0003_0000, 0, 0);
      send_word(0, 16'hFFFF, 0, 32'sh7FFF_FFFF, 0, 0);
      send_word(0, 16'h8000, 1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_word(0, 16'h1234, 1, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      send_word(0, 16'h0001, 1, 32'sh8000_0010, 32'sh8000_0000, 32'sh8000_0000);
      send_word(1, 16'hFFFF, 1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_word(1, 16'h0, 0, 0, 0, 0);
      send_word(0, 16'h4000, 1, 32'sh0000_1000, 0, 0);

      // one segment: trail fills and drops quickly
      configure(32'h0004_0000, 1, 0, 0, 0, 0);
      send_word(0, 16'h8000, 1, 32'sh0004_0000, 0, 0);
      send_word(0, 16'h8000, 1, 32'sh0008_0000, 0, 0);
      send_word(0, 16'h8000, 1, 32'sh0010_0000, 32'sh0010_0000, 0);
      send_word(0, 16'h8000, 1, 32'sh0010_0000, 32'sh0010_0000, 0);

      // zero interval and extreme force, links collapse
      configure(0, 4, 1000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_1234);
      send_word(0, 16'hFFFF, 1, 1, 2, 3);
      send_word(0, 16'hFFFF, 1, 1, 2, 3);
      send_word(0, 16'hFFFF, 1, 32'sh7FFF_0000, 0, 0);
      send_word(0, 16'h0001, 1, 32'sh8000_0000, 0, 0);
      random_words(20);

      configure(32'h7FFF_FFFF, 32, 32'h00FF_FFFF, 0, 0, 0);
      random_words(20);
      no_idle = 1;
      configure(32'h0001_0000, 8, $urandom_range(0, 32'hFFFFFF),
                $urandom_range(0, 32'h3_0000) - 32'h1_8000,
                $urandom_range(0, 32'h3_0000) - 32'h1_8000,
                $urandom_range(0, 32'h3_0000) - 32'h1_8000);
      random_words(40);
      no_idle = 0;
      configure($urandom_range(1, 32'h0004_0000), 32, $urandom_range(0, 4096), 0, 0, 0);
      random_words(60);
      // lowered limit with a long trail left in place
      configure(32'h0001_0000, 3, $urandom_range(0, 32'hFFFFFF), $urandom, $urandom, $urandom);
      random_words(30);
      configure($urandom_range(1, 32'h0010_0000), 0, $urandom_range(0, 32'hFFFF), 0, 0, 0);
      random_words(20);
      configure($urandom_range(1, 32'h0002_0000), 63, $urandom_range(0, 8192), 0, 0, 0);
      random_words(40);
      configure(32'h0000_8000, 32, 16, 32'h0000_4000, 32'hFFFF_C000, 32'h0001_0000);
      send_word(1, 0, 0, 0, 0, 0);
      random_words(12);
      configure($urandom_range(1, 32'h7FFF_FFFF), 6, $urandom, $urandom, $urandom, 0);
      random_words(28);

      wait_drained();
      repeat (100) @(posedge clock);
      $display("sent %0d words, checked %0d trail points over eleven register settings",
               words_sent, words_seen);
      $display("covered seeding, shifts, fade decay, force pull, clears and full trails");
      if (trail_sb.errors == 0 && trail_sb.pending.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/thu_pkg.sv
rtl/core/thu_trail_mem.sv
rtl/core/thu_arith.sv
rtl/core/trail_history_update_core.sv
test/tb_top.sv
